// File: src/hhm_pkg.sv
// Shared types and constants for the hotness hotlist monitor.
// Holds the item layouts, operation and register codes and fixed widths.
// No dependencies; imported by every module of the block.
package hhm_pkg;

   // Fixed field widths
   localparam int ADDR_BITS    = 34;
   localparam int PTR_FIELD_W  = 6;
   localparam int WORD_W       = 32;
   localparam int SIZE_W       = 5;
   localparam int MAP_SPAN_BIT = 33;
   localparam int MAP_BIT_LSB  = 28;
   localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 5'd28;

   // Stream widths, padded to whole bytes
   localparam int REQ_ITEM_W  = 86;
   localparam int REQ_TDATA_W = 88;
   localparam int RSP_ITEM_W  = 50;
   localparam int RSP_TDATA_W = 56;

   // Register file port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      OP_TICK      = 3'd0,
      OP_WR_PTRS   = 3'd1,
      OP_WR_OVF    = 3'd2,
      OP_RD_ENTRY  = 3'd3,
      OP_RD_PTRS   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_ENABLE   = 3'd0,
      REG_EPOCH    = 3'd1,
      REG_UNIT_SZ  = 3'd2,
      REG_MAP_LOW  = 3'd3,
      REG_MAP_HIGH = 3'd4
   } reg_idx_type;

   // Input item, first field in the highest bits
   typedef struct packed {
      logic [PTR_FIELD_W-1:0] entry_index;
      logic                   overflow_value;
      logic [PTR_FIELD_W-1:0] tail_value;
      logic [PTR_FIELD_W-1:0] head_value;
      logic [WORD_W-1:0]      random_count;
      logic [WORD_W-1:0]      random_unit;
      logic [2:0]             operation;
   } req_item_type;

   // Result item, first field in the highest bits
   typedef struct packed {
      logic                   entry_added;
      logic                   interrupt_pulse;
      logic                   monitor_active;
      logic                   overflow_status;
      logic [PTR_FIELD_W-1:0] read_tail;
      logic [PTR_FIELD_W-1:0] read_head;
      logic [ADDR_BITS-1:0]   read_entry;
   } rsp_item_type;

   // Monitor configuration handed to the entry generator
   typedef struct packed {
      logic              epoch_mode;
      logic [SIZE_W-1:0] size_log2;
      logic [WORD_W-1:0] map_low;
      logic [WORD_W-1:0] map_high;
   } mon_cfg_type;

   // Candidate hotlist entry for a tick
   typedef struct packed {
      logic                 tracked;
      logic [ADDR_BITS-1:0] entry;
   } gen_result_type;

endpackage

// File: src/hhm_entry_gen.sv
// Candidate entry builder: masks the random unit and count, checks the range maps
// and forms the 34-bit hotlist entry. Pure combinational logic.
// Depends on hhm_pkg.
module hhm_entry_gen (
   input  hhm_pkg::mon_cfg_type    cfg,
   input  logic [31:0]             random_unit,
   input  logic [31:0]             random_count,
   output hhm_pkg::gen_result_type result
);
   import hhm_pkg::*;

   logic [WORD_W-1:0]    unit_mask;
   logic [WORD_W-1:0]    unit_masked;
   logic [WORD_W-1:0]    count_masked;
   logic [ADDR_BITS-1:0] unit_addr;
   logic [4:0]           map_bit;
   logic [WORD_W-1:0]    map_sel;

   // Unit id keeps 34 - size_log2 bits, all 32 when the size is two or less
   always_comb begin
      if (cfg.size_log2 <= 5'd2) begin
         unit_mask = '1;
      end else begin
         unit_mask = {WORD_W{1'b1}} >> (cfg.size_log2 - 5'd2);
      end
   end

   assign unit_masked  = random_unit & unit_mask;
   assign count_masked = cfg.epoch_mode ? (random_count & ~({WORD_W{1'b1}} << cfg.size_log2))
                                        : '0;

   // Place the unit in the address space and pick the map bit
   assign unit_addr = {2'b00, unit_masked} << cfg.size_log2;
   assign map_bit   = unit_addr[MAP_SPAN_BIT-1:MAP_BIT_LSB];
   assign map_sel   = unit_addr[MAP_SPAN_BIT] ? cfg.map_high : cfg.map_low;

   assign result.tracked = map_sel[map_bit];
   assign result.entry   = unit_addr + {2'b00, count_masked};

endmodule

// File: src/hhm_store.sv
// Hotlist ring storage: one write port, one registered read port.
// A read that meets a write to the same slot at the same edge returns the new entry.
// Depends on hhm_pkg.
module hhm_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [hhm_pkg::ADDR_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [hhm_pkg::ADDR_BITS-1:0] rd_data
);
   import hhm_pkg::*;

   logic [ADDR_BITS-1:0] mem [DEPTH];
   logic [ADDR_BITS-1:0] rd_data_ff;

   // Write the slot at the tail
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read, forwarding a same-edge write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hotness_hotlist_monitor_unit.sv
// Top level of the hotness hotlist monitor: stream ports, register file,
// input stage, ring pointers and flags, and result register.
// Depends on hhm_pkg, hhm_entry_gen and hhm_store.
//
//   port group | direction | contents
//   req_*      | in        | one operation per transfer (tick, pointer/flag write, reads)
//   rsp_*      | out       | one result per operation: entry, pointers, flags
//   csr_*      | in/out    | registers: enable, epoch mode, unit size, two range maps
//
// One operation per cycle sustained while rsp_tready is high; each result is offered on rsp_*
// after its request passes the input stage (with the ring read), then the result register.
// Reset clears pointers, flags, registers and both stage valids; ring slots
// are left as they are. A stalled result holds the input stage, and req_tready
// drops only while both stages are full and rsp_tready is low.
module hotness_hotlist_monitor_unit #(
   parameter int HOTLIST_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // operation[2:0], random_unit[34:3], random_count[66:35], head_value[72:67],
   // tail_value[78:73], overflow_value[79], entry_index[85:80], zero pad[87:86]
   input  logic [hhm_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_entry[33:0], read_head[39:34], read_tail[45:40], overflow_status[46],
   // monitor_active[47], interrupt_pulse[48], entry_added[49], zero pad[55:50]
   output logic [hhm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hhm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [hhm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [hhm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import hhm_pkg::*;

   localparam int PW = (HOTLIST_DEPTH > 1) ? $clog2(HOTLIST_DEPTH) : 1;
   localparam int PTR_VALUES = 1 << PTR_FIELD_W;

   // Configuration registers
   logic              enable_ff;
   logic              epoch_ff;
   logic [SIZE_W-1:0] size_log2_ff;
   logic [WORD_W-1:0] map_low_ff;
   logic [WORD_W-1:0] map_high_ff;
   logic              csr_wr;
   reg_idx_type       csr_idx;

   // Pipeline
   req_item_type   req_item;
   logic           accept;
   logic           advance;
   logic           s1_valid_ff;
   req_item_type   s1_item_ff;
   logic           rsp_valid_ff;
   rsp_item_type   rsp_item_ff;
   rsp_item_type   rsp_item_in;

   // Ring state
   logic [PW-1:0]  head_ff, head_in;
   logic [PW-1:0]  tail_ff, tail_in;
   logic           ovf_ff, ovf_in;
   logic           active_ff, active_in;
   logic [PW-1:0]  tail_next;
   logic           ring_full;
   logic [PW-1:0]  ptr_mod [PTR_VALUES];

   // Entry path
   mon_cfg_type          mon_cfg;
   gen_result_type       gen;
   logic                 wr_en;
   logic [ADDR_BITS-1:0] rd_data;
   logic                 entry_in_range;
   logic                 pulse;
   logic                 added;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         epoch_ff     <= 1'b0;
         size_log2_ff <= SIZE_LOG2_RESET;
         map_low_ff   <= '0;
         map_high_ff  <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ENABLE:   enable_ff    <= csr_pwdata[0];
            REG_EPOCH:    epoch_ff     <= csr_pwdata[0];
            REG_UNIT_SZ:  size_log2_ff <= csr_pwdata[SIZE_W-1:0];
            REG_MAP_LOW:  map_low_ff   <= csr_pwdata;
            REG_MAP_HIGH: map_high_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ENABLE:   csr_prdata = {31'd0, enable_ff};
         REG_EPOCH:    csr_prdata = {31'd0, epoch_ff};
         REG_UNIT_SZ:  csr_prdata = {27'd0, size_log2_ff};
         REG_MAP_LOW:  csr_prdata = map_low_ff;
         REG_MAP_HIGH: csr_prdata = map_high_ff;
         default:      csr_prdata = '0;
      endcase
   end

   // Handshakes: the input stage advances whenever the result register frees up
   assign req_item   = req_item_type'(req_tdata[REQ_ITEM_W-1:0]);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= req_item;
      end
   end

   // Pointer values reduced modulo the ring depth
   for (genvar g = 0; g < PTR_VALUES; g++) begin : g_ptr_mod
      assign ptr_mod[g] = PW'(g % HOTLIST_DEPTH);
   end

   // Candidate entry for a tick
   assign mon_cfg.epoch_mode = epoch_ff;
   assign mon_cfg.size_log2  = size_log2_ff;
   assign mon_cfg.map_low    = map_low_ff;
   assign mon_cfg.map_high   = map_high_ff;

   hhm_entry_gen u_entry_gen (
      .cfg          (mon_cfg),
      .random_unit  (s1_item_ff.random_unit),
      .random_count (s1_item_ff.random_count),
      .result       (gen)
   );

   // Ring full when the tail would run into the head
   assign tail_next = (tail_ff == PW'(HOTLIST_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign ring_full = (head_ff == tail_next);

   // Apply one operation to the ring state
   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      ovf_in    = ovf_ff;
      active_in = active_ff;
      pulse     = 1'b0;
      added     = 1'b0;
      wr_en     = 1'b0;
      case (op_type'(s1_item_ff.operation))
         OP_TICK: begin
            active_in = enable_ff;
            if (enable_ff) begin
               if (ring_full) begin
                  if (!ovf_ff) begin
                     ovf_in = 1'b1;
                     pulse  = 1'b1;
                  end
               end else if (gen.tracked) begin
                  wr_en   = advance;
                  tail_in = tail_next;
                  added   = 1'b1;
               end
            end
         end
         OP_WR_PTRS: begin
            head_in = ptr_mod[s1_item_ff.head_value];
            tail_in = ptr_mod[s1_item_ff.tail_value];
         end
         OP_WR_OVF: begin
            ovf_in = s1_item_ff.overflow_value;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         tail_ff   <= '0;
         ovf_ff    <= 1'b0;
         active_ff <= 1'b0;
      end else if (advance) begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         ovf_ff    <= ovf_in;
         active_ff <= active_in;
      end
   end

   // Ring storage, read as the item enters the input stage
   hhm_store #(
      .DEPTH  (HOTLIST_DEPTH),
      .ADDR_W (PW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (gen.entry),
      .rd_en   (accept),
      .rd_addr (PW'(req_item.entry_index)),
      .rd_data (rd_data)
   );

   assign entry_in_range = ({26'd0, s1_item_ff.entry_index} < 32'(HOTLIST_DEPTH));

   // Build the result
   always_comb begin
      rsp_item_in.read_entry      = '0;
      if ((op_type'(s1_item_ff.operation) == OP_RD_ENTRY) && entry_in_range) begin
         rsp_item_in.read_entry   = rd_data;
      end
      rsp_item_in.read_head       = PTR_FIELD_W'(head_in);
      rsp_item_in.read_tail       = PTR_FIELD_W'(tail_in);
      rsp_item_in.overflow_status = ovf_in;
      rsp_item_in.monitor_active  = active_in;
      rsp_item_in.interrupt_pulse = pulse;
      rsp_item_in.entry_added     = added;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - RSP_ITEM_W){1'b0}}, rsp_item_ff};

   // A pulse only comes with the overflow flag set
   a_pulse_sets_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.interrupt_pulse |-> rsp_item_ff.overflow_status)
      else $error("interrupt pulse without overflow status");

   // A tick may store an entry or raise the overflow, never both
   a_pulse_xor_add: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_item_ff.interrupt_pulse && rsp_item_ff.entry_added))
      else $error("entry stored on an overflowing tick");

   // An entry is stored only by an enabled tick
   a_add_active: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_item_ff.entry_added |-> rsp_item_ff.monitor_active)
      else $error("entry stored while the monitor was inactive");

   // The ring write advances the tail by one slot
   a_tail_step: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (tail_ff == $past(tail_next)))
      else $error("tail did not advance after a ring write");

   // A held input stage keeps its item
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("input stage dropped a stalled item");

endmodule
